// ===== rtl/btr_pkg.sv =====
// ----------------------------------------------------------------------------
// btr_pkg: shared types and constants of the block transpose reorder unit
// Holds the state encoding, the command and status bundles between the
// controller and the datapath, and the register map of the config port.
// ----------------------------------------------------------------------------
package btr_pkg;

    // Config port geometry.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 4;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_ROWS    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLUMNS = 2'd1;

    // Reset values of the dimension registers.
    localparam logic [CFG_DATA_W-1:0] ROWS_RESET    = 4'd2;
    localparam logic [CFG_DATA_W-1:0] COLUMNS_RESET = 4'd2;

    // Stream field widths.
    localparam int ITEM_PORT_W = 16;

    // Controller states, one-hot.
    typedef enum logic [1:0] {
        ST_FILL  = 2'b01,
        ST_DRAIN = 2'b10
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr_en;          // store the accepted beat
        logic load_transpose; // block completed, set up a column-major drain
        logic load_tail;      // end mark on a partial block, set up a tail drain
        logic rd_step;        // read one entry into the output register
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fill_full;      // the next stored beat completes the block
        logic out_free;       // the output register can take a new entry
        logic drain_last;     // the current drain entry is the final one
    } ctrl_status_t;

endpackage

// ===== rtl/block_transpose_reorder_unit.sv =====
// ----------------------------------------------------------------------------
// block_transpose_reorder_unit: block corner turn of a tag stream
// Order: the beat that completes a block or carries the end mark sets the drain
// state; each drain read step then loads one entry into the output register.
// Throughput: one input beat per cycle while filling; a drain of N entries
// holds input and steps only while the output register can take an entry.
// Reset: synchronous, active low; block empty, both dimensions 2, store not cleared.
// ----------------------------------------------------------------------------
module block_transpose_reorder_unit #(
    parameter int MAX_ROWS    = 8,
    parameter int MAX_COLUMNS = 8,
    parameter int ITEM_WIDTH  = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Config write port.
    input  logic                                 cfg_we,
    input  logic [btr_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [btr_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    // Input stream.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [btr_pkg::ITEM_PORT_W-1:0]      s_tdata,  // [15:0] item
    input  logic                                 s_tlast,  // end_of_input
    // Result stream.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [btr_pkg::ITEM_PORT_W-1:0]      m_tdata,  // [15:0] item_out
    output logic                                 m_tlast,  // last_of_run
    output logic [0:0]                           m_tuser   // [0] partial_tail
);

    // The controller only decides when to take a beat and when to step a
    // drain; the datapath owns the store, the counters and the output
    // register, so a finished result can wait while the next block fills.
    btr_pkg::ctrl_cmd_t    cmd;
    btr_pkg::ctrl_status_t status;
    logic                  tail_flag;

    btr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    btr_datapath #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS),
        .ITEM_WIDTH  (ITEM_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .item_in   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .item_out  (m_tdata),
        .out_last  (m_tlast),
        .out_tail  (tail_flag)
    );

    assign m_tuser = tail_flag;

`ifndef SYNTHESIS
    // A beat with the end mark always starts a drain, so input stops.
    a_end_stops_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input still taken after an end-marked beat");

    // Every drain step presents a result beat in the following cycle.
    a_step_shows_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_step |=> m_tvalid)
        else $error("drain step produced no result beat");

    // The final drain step of a block returns the unit to filling.
    a_last_step_refills: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_step && status.drain_last |=> s_tready && m_tlast)
        else $error("drain did not end on the final entry");
`endif

endmodule

// ===== rtl/btr_ctrl.sv =====
// ----------------------------------------------------------------------------
// btr_ctrl: sequencing of fill and drain phases
// Accepts beats while filling and steps the datapath through a drain once a
// block completes or an end mark arrives.
// ----------------------------------------------------------------------------
module btr_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tlast,
    output logic                  s_tready,
    input  btr_pkg::ctrl_status_t status,
    output btr_pkg::ctrl_cmd_t    cmd
);

    btr_pkg::ctrl_state_t state_reg;
    btr_pkg::ctrl_state_t state_next;
    logic                 accept;

    assign s_tready = (state_reg == btr_pkg::ST_FILL);
    assign accept   = s_tready && s_tvalid;

    always_comb begin
        cmd.wr_en          = accept;
        cmd.load_transpose = accept && status.fill_full;
        cmd.load_tail      = accept && !status.fill_full && s_tlast;
        cmd.rd_step        = (state_reg == btr_pkg::ST_DRAIN) && status.out_free;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            btr_pkg::ST_FILL: begin
                if (cmd.load_transpose || cmd.load_tail) begin
                    state_next = btr_pkg::ST_DRAIN;
                end
            end
            btr_pkg::ST_DRAIN: begin
                if (cmd.rd_step && status.drain_last) begin
                    state_next = btr_pkg::ST_FILL;
                end
            end
            default: begin
                state_next = btr_pkg::ST_FILL;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= btr_pkg::ST_FILL;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/btr_datapath.sv =====
// ----------------------------------------------------------------------------
// btr_datapath: block store, address generation and output register
// Writes beats row-major into the store and reads them back column-major or
// in arrival order into the output register.
// ----------------------------------------------------------------------------
module btr_datapath #(
    parameter int MAX_ROWS    = 8,
    parameter int MAX_COLUMNS = 8,
    parameter int ITEM_WIDTH  = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [btr_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [btr_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic [btr_pkg::ITEM_PORT_W-1:0]      item_in,
    input  btr_pkg::ctrl_cmd_t                   cmd,
    output btr_pkg::ctrl_status_t                status,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic [btr_pkg::ITEM_PORT_W-1:0]      item_out,
    output logic                                 out_last,
    output logic                                 out_tail
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLUMNS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int RN_W   = $clog2(MAX_ROWS + 1);
    localparam int CN_W   = $clog2(MAX_COLUMNS + 1);
    localparam int RI_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CI_W   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    logic [btr_pkg::CFG_DATA_W-1:0] rows_reg;
    logic [btr_pkg::CFG_DATA_W-1:0] columns_reg;
    logic [RN_W-1:0]                r_n;
    logic [CN_W-1:0]                c_n;
    logic [CNT_W-1:0]               size;
    logic                           dim_write;

    logic [CNT_W-1:0]               fill_count_reg;
    logic [CNT_W-1:0]               fill_plus_one;

    logic [ITEM_WIDTH-1:0]          mem [DEPTH];
    logic [ITEM_WIDTH-1:0]          item_store;
    logic [ITEM_WIDTH-1:0]          out_data_reg;

    logic                           tail_mode_reg;
    logic [CNT_W-1:0]               n_reg;
    logic [CNT_W-1:0]               total_reg;
    logic [ADDR_W-1:0]              addr_reg;
    logic [RI_W-1:0]                r_reg;
    logic [CI_W-1:0]                c_reg;
    logic                           out_valid_reg;
    logic                           out_last_reg;
    logic                           out_tail_reg;

    // Dimension registers; a write to either of them drops the partial block.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg    <= btr_pkg::ROWS_RESET;
            columns_reg <= btr_pkg::COLUMNS_RESET;
        end else if (cfg_we) begin
            if (cfg_index == btr_pkg::CFG_ROWS) begin
                rows_reg <= cfg_wdata;
            end
            if (cfg_index == btr_pkg::CFG_COLUMNS) begin
                columns_reg <= cfg_wdata;
            end
        end
    end

    // Only a write to a real dimension register clears the block.
    assign dim_write = cfg_we && ((cfg_index == btr_pkg::CFG_ROWS) ||
                                  (cfg_index == btr_pkg::CFG_COLUMNS));

    // A zero dimension acts as one, an oversized one as the maximum.
    always_comb begin
        if (rows_reg == '0) begin
            r_n = RN_W'(1);
        end else if (rows_reg > btr_pkg::CFG_DATA_W'(MAX_ROWS)) begin
            r_n = RN_W'(MAX_ROWS);
        end else begin
            r_n = RN_W'(rows_reg);
        end
        if (columns_reg == '0) begin
            c_n = CN_W'(1);
        end else if (columns_reg > btr_pkg::CFG_DATA_W'(MAX_COLUMNS)) begin
            c_n = CN_W'(MAX_COLUMNS);
        end else begin
            c_n = CN_W'(columns_reg);
        end
    end

    assign size          = CNT_W'(r_n) * CNT_W'(c_n);
    assign fill_plus_one = fill_count_reg + CNT_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_count_reg <= '0;
        end else if (dim_write) begin
            fill_count_reg <= '0;
        end else if (cmd.load_transpose || cmd.load_tail) begin
            fill_count_reg <= '0;
        end else if (cmd.wr_en) begin
            fill_count_reg <= fill_plus_one;
        end
    end

    // Fit the port-wide tag to the stored width and back.
    generate
        if (ITEM_WIDTH >= btr_pkg::ITEM_PORT_W) begin : g_wide
            assign item_store = ITEM_WIDTH'(item_in);
            assign item_out   = out_data_reg[btr_pkg::ITEM_PORT_W-1:0];
        end else begin : g_narrow
            assign item_store = item_in[ITEM_WIDTH-1:0];
            assign item_out   = {{(btr_pkg::ITEM_PORT_W - ITEM_WIDTH){1'b0}}, out_data_reg};
        end
    endgenerate

    // Block store; the read port feeds the output register directly.
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[fill_count_reg[ADDR_W-1:0]] <= item_store;
        end
        if (cmd.rd_step) begin
            out_data_reg <= mem[addr_reg];
        end
    end

    // Drain address generation.
    always_ff @(posedge aclk) begin
        if (cmd.load_transpose) begin
            tail_mode_reg <= 1'b0;
            total_reg     <= size;
            n_reg         <= '0;
            addr_reg      <= '0;
            r_reg         <= '0;
            c_reg         <= '0;
        end else if (cmd.load_tail) begin
            tail_mode_reg <= 1'b1;
            total_reg     <= fill_plus_one;
            n_reg         <= '0;
            addr_reg      <= '0;
            r_reg         <= '0;
            c_reg         <= '0;
        end else if (cmd.rd_step) begin
            n_reg <= n_reg + CNT_W'(1);
            if (tail_mode_reg) begin
                addr_reg <= addr_reg + ADDR_W'(1);
            end else if (r_reg == RI_W'(r_n - RN_W'(1))) begin
                // Column done: restart at the top of the next column.
                r_reg    <= '0;
                c_reg    <= c_reg + CI_W'(1);
                addr_reg <= ADDR_W'(c_reg) + ADDR_W'(1);
            end else begin
                r_reg    <= r_reg + RI_W'(1);
                addr_reg <= addr_reg + ADDR_W'(c_n);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.rd_step) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_step) begin
            out_last_reg <= status.drain_last;
            out_tail_reg <= tail_mode_reg;
        end
    end

    always_comb begin
        status.fill_full  = (fill_plus_one == size);
        status.out_free   = !out_valid_reg || out_ready;
        status.drain_last = (n_reg == total_reg - CNT_W'(1));
    end

    assign out_valid = out_valid_reg;
    assign out_last  = out_last_reg;
    assign out_tail  = out_tail_reg;

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking testbench of block_transpose_reorder_unit
// Drives tagged beats through the corner turn at several block shapes, with
// random gaps on both stream sides. A local model of the block store predicts
// every transposed block and every partial tail, and each result beat is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

    localparam int MAX_ROWS      = 8;
    localparam int MAX_COLUMNS   = 8;
    localparam int ITEM_TARGET   = 310;     // least number of beats sent over the whole run
    localparam int SETTLE_CYCLES = 8;       // covers the result latency
    localparam int CYCLE_LIMIT   = 400000;  // far above the slowest legal run
    localparam int PRINT_LIMIT   = 40;

    // Register indexes with no register behind them; writes there are ignored.
    localparam logic [btr_pkg::CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [btr_pkg::CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

    // One predicted result beat.
    typedef struct packed {
        logic [btr_pkg::ITEM_PORT_W-1:0] tag;
        logic                            last;
        logic                            tail;
    } out_beat_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [btr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [btr_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [btr_pkg::ITEM_PORT_W-1:0] s_tdata   = '0;
    logic                            s_tlast   = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [btr_pkg::ITEM_PORT_W-1:0] m_tdata;
    logic                            m_tlast;
    logic [0:0]                      m_tuser;

    // Local copy of the block state and the dimension registers.
    logic [btr_pkg::ITEM_PORT_W-1:0] block_mem [MAX_ROWS*MAX_COLUMNS];
    int unsigned                     fill_cnt;
    logic [btr_pkg::CFG_DATA_W-1:0]  rows_reg;
    logic [btr_pkg::CFG_DATA_W-1:0]  cols_reg;

    // Reordered tags still waiting to leave the block, oldest first.
    out_beat_t reordered_q[$];

    int unsigned cycle_count    = 0;
    int unsigned mismatch_count = 0;
    int unsigned beats_sent     = 0;
    int unsigned random_beats   = 0;
    int unsigned beats_checked  = 0;
    int unsigned blocks_done    = 0;
    int unsigned tails_done     = 0;
    int unsigned dim_writes     = 0;
    bit          quiet_mode     = 1'b0;  // no gaps on either side while set
    int unsigned stall_left     = 0;

    block_transpose_reorder_unit #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLUMNS(MAX_COLUMNS),
        .ITEM_WIDTH (btr_pkg::ITEM_PORT_W)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #2 aclk = ~aclk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d result beats still pending.",
                     cycle_count, reordered_q.size());
            $display("** block_transpose_reorder_unit: FAILED **");
            $finish;
        end
    end

    // Gap length for either side: mostly none, often short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (quiet_mode || roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // A dimension of zero behaves as one, any above the maximum as the maximum.
    function automatic int unsigned eff_dim(logic [btr_pkg::CFG_DATA_W-1:0] v,
                                            int unsigned lim);
        if (v == 0)
            return 1;
        if (v > lim)
            return lim;
        return 32'(v);
    endfunction

    function automatic int unsigned block_size();
        return eff_dim(rows_reg, MAX_ROWS) * eff_dim(cols_reg, MAX_COLUMNS);
    endfunction

    // Appends one predicted beat behind the ones still waiting.
    function automatic void queue_beat(out_beat_t b);
        reordered_q.insert(reordered_q.size(), b);
    endfunction

    // Stores one accepted beat row-major. A full block is read back
    // column-major; an end mark on an unfinished block flushes what is stored
    // in arrival order. Either way the block starts empty afterwards.
    function automatic void corner_turn(logic [btr_pkg::ITEM_PORT_W-1:0] tag, logic eoi);
        int unsigned nr;
        int unsigned nc;
        int unsigned total;
        int unsigned k;
        out_beat_t   b;
        nr    = eff_dim(rows_reg, MAX_ROWS);
        nc    = eff_dim(cols_reg, MAX_COLUMNS);
        total = nr * nc;
        if (fill_cnt >= total)
            fill_cnt = 0;
        block_mem[fill_cnt] = tag;
        fill_cnt++;
        if (fill_cnt == total) begin
            k = 0;
            for (int c = 0; c < nc; c++) begin
                for (int r = 0; r < nr; r++) begin
                    k++;
                    b.tag  = block_mem[r*nc + c];
                    b.last = (k == total);
                    b.tail = 1'b0;
                    queue_beat(b);
                end
            end
            fill_cnt = 0;
            blocks_done++;
        end else if (eoi) begin
            for (int i = 0; i < fill_cnt; i++) begin
                b.tag  = block_mem[i];
                b.last = (i + 1 == fill_cnt);
                b.tail = 1'b1;
                queue_beat(b);
            end
            fill_cnt = 0;
            tails_done++;
        end
    endfunction

    task automatic report_mismatch(string what, logic [btr_pkg::ITEM_PORT_W-1:0] got,
                                   logic [btr_pkg::ITEM_PORT_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("Mismatch at cycle %0d: %s is %h, predicted %h",
                     cycle_count, what, got, want);
    endtask

    // Compares one accepted result beat with the oldest prediction.
    task automatic check_result_beat();
        out_beat_t want;
        beats_checked++;
        if (reordered_q.size() == 0) begin
            report_mismatch("unpredicted result beat, item_out", m_tdata, '0);
            return;
        end
        want = reordered_q.pop_front();
        if (m_tdata !== want.tag)
            report_mismatch("item_out", m_tdata, want.tag);
        if (m_tlast !== want.last)
            report_mismatch("last_of_run", btr_pkg::ITEM_PORT_W'(m_tlast),
                            btr_pkg::ITEM_PORT_W'(want.last));
        if (m_tuser[0] !== want.tail)
            report_mismatch("partial_tail", btr_pkg::ITEM_PORT_W'(m_tuser[0]),
                            btr_pkg::ITEM_PORT_W'(want.tail));
    endtask

    // Result side: check each accepted beat, then decide the next ready.
    // Signals are read right after the edge, so they hold pre-edge values.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left  = 0;
        end else begin
            if (m_tvalid && m_tready)
                check_result_beat();
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready  <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // Sends one beat. Valid is left high after acceptance so that a beat with
    // no gap follows directly; it is lowered where a gap starts or at settle().
    task automatic send_item(logic [btr_pkg::ITEM_PORT_W-1:0] tag, logic eoi);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= tag;
        s_tlast  <= eoi;
        do @(posedge aclk); while (!s_tready);
        corner_turn(tag, eoi);
        beats_sent++;
    endtask

    // Random beats; a clean run carries its end mark on the final beat only,
    // a noisy run scatters end marks.
    task automatic send_run(int unsigned len, bit noisy);
        logic eoi;
        for (int i = 0; i < len; i++) begin
            if (noisy)
                eoi = ($urandom_range(0, 7) == 0);
            else
                eoi = (i == len - 1);
            send_item(16'($urandom()), eoi);
            random_beats++;
        end
    endtask

    // Waits until the block is idle: every predicted beat out, plus a margin
    // for a beat that is still being stored.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (reordered_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [btr_pkg::CFG_INDEX_W-1:0] idx,
                             logic [btr_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            btr_pkg::CFG_ROWS: begin
                rows_reg = val;
                fill_cnt = 0;
                dim_writes++;
            end
            btr_pkg::CFG_COLUMNS: begin
                cols_reg = val;
                fill_cnt = 0;
                dim_writes++;
            end
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Reset shape 2x2: a full block with extreme tags, a tail of three, a
    // tail of one, and an end mark that lands on the completing beat.
    task automatic test_default_block();
        send_item(16'h0000, 1'b0);
        send_item(16'hFFFF, 1'b0);
        send_item(16'h5555, 1'b0);
        send_item(16'hAAAA, 1'b0);
        send_item(16'h1234, 1'b0);
        send_item(16'h8001, 1'b0);
        send_item(16'h7FFE, 1'b1);
        send_item(16'hFFFF, 1'b1);
        for (int i = 0; i < 4; i++)
            send_item(16'($urandom()), i == 3);
        settle();
    endtask

    // Writes to spare indexes keep a partial block; dimension writes drop it.
    task automatic test_register_writes();
        send_item(16'hC0DE, 1'b0);
        send_item(16'h0001, 1'b0);
        send_item(16'h8000, 1'b0);
        settle();
        cfg_write(CFG_SPARE_A, 4'hF);
        send_item(16'hBEEF, 1'b0);   // completes the block started before
        settle();
        send_item(16'h4242, 1'b0);
        send_item(16'h2424, 1'b0);
        settle();
        cfg_write(CFG_SPARE_B, 4'h0);
        cfg_write(btr_pkg::CFG_ROWS, 4'd1);     // 1x2, the two stored beats are dropped
        send_item(16'hFFFF, 1'b0);
        send_item(16'h0000, 1'b1);
        settle();
        cfg_write(btr_pkg::CFG_COLUMNS, 4'd1);  // 1x1, every beat is a whole block
        send_item(16'h7FFF, 1'b0);
        send_item(16'h8000, 1'b1);
        settle();
    endtask

    // Extreme and clamped shapes: a full block at each, then a tail of zero to five.
    task automatic test_dimension_sweep();
        logic [btr_pkg::CFG_DATA_W-1:0] sweep_rows [9] = '{4'd0, 4'd15, 4'd0, 4'd15,
                                                           4'd1, 4'd8, 4'd9, 4'd3, 4'd4};
        logic [btr_pkg::CFG_DATA_W-1:0] sweep_cols [9] = '{4'd0, 4'd15, 4'd15, 4'd0,
                                                           4'd8, 4'd1, 4'd3, 4'd9, 4'd5};
        int unsigned size;
        int unsigned tail_len;
        for (int i = 0; i < 9; i++) begin
            cfg_write(btr_pkg::CFG_ROWS, sweep_rows[i]);
            cfg_write(btr_pkg::CFG_COLUMNS, sweep_cols[i]);
            quiet_mode = ($urandom_range(0, 3) == 0);
            size       = block_size();
            tail_len   = (size > 1) ? $urandom_range(0, (size - 1 < 5) ? size - 1 : 5) : 0;
            send_run(size + tail_len, 1'b0);
            settle();
        end
        quiet_mode = 1'b0;
    endtask

    // Random shapes, mostly small; mostly clean runs of whole blocks plus a
    // tail, the rest noisy runs. Partial blocks may carry across phases when
    // no dimension is rewritten.
    task automatic test_random_stream();
        int unsigned size;
        int unsigned len;
        while (beats_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 3) != 0) begin
                if ($urandom_range(0, 4) != 0) begin
                    cfg_write(btr_pkg::CFG_ROWS, 4'($urandom_range(1, 4)));
                    cfg_write(btr_pkg::CFG_COLUMNS, 4'($urandom_range(1, 4)));
                end else begin
                    cfg_write(btr_pkg::CFG_ROWS, 4'($urandom_range(0, 15)));
                    cfg_write(btr_pkg::CFG_COLUMNS, 4'($urandom_range(0, 3)));
                end
                if ($urandom_range(0, 5) == 0)
                    cfg_write($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                              4'($urandom()));
            end
            quiet_mode = ($urandom_range(0, 3) == 0);
            size       = block_size();
            for (int s = $urandom_range(1, 3); s > 0; s--) begin
                if ($urandom_range(0, 4) != 0) begin
                    len = size * $urandom_range(0, (size > 16) ? 1 : 2)
                          + $urandom_range(0, size - 1);
                    send_run((len == 0) ? 1 : len, 1'b0);
                end else begin
                    send_run($urandom_range(1, 12), 1'b1);
                end
            end
            settle();
        end
        quiet_mode = 1'b0;
    endtask

    initial begin
        fill_cnt = 0;
        rows_reg = btr_pkg::ROWS_RESET;
        cols_reg = btr_pkg::COLUMNS_RESET;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_block();
        test_register_writes();
        test_dimension_sweep();
        test_random_stream();

        // Everything is settled by now; a stray late beat would still be caught.
        repeat (4 * SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d beats (%0d random) over %0d dimension writes, shapes 1x1 to 8x8.",
                 beats_sent, random_beats, dim_writes);
        $display("Checked %0d result beats: %0d transposed blocks, %0d partial tails.",
                 beats_checked, blocks_done, tails_done);
        if (mismatch_count == 0 && reordered_q.size() == 0)
            $display("** block_transpose_reorder_unit: PASSED **");
        else
            $display("** block_transpose_reorder_unit: FAILED **");
        $finish;
    end

endmodule
